### sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while the active-low reset is asserted.
`define ECPG_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Signal must hold its value in the cycle after a condition.
`define ECPG_ASSERT_HOLD(label, clk, rst_n, cond, sig, msg) \
    `ECPG_ASSERT(label, clk, rst_n, (cond) |=> $stable(sig), msg)

`endif

### sv/ecpg_pkg.sv
package ecpg_pkg;

    localparam int MAX_POINTS    = 1024;
    localparam int IDX_W         = 10;
    localparam int ANG_W         = 17;
    localparam int PROD_W        = 28;
    localparam int Q30_W         = 31;
    localparam int GAIN_W        = 17;
    localparam int CORDIC_STEPS  = 24;
    localparam int CORDIC_LAT    = CORDIC_STEPS + 1;
    localparam int DIV_STEPS     = 16;
    localparam int DIV_LAT       = DIV_STEPS + 1;
    localparam int CW            = 34;

    localparam logic [PROD_W-1:0] HALF_PI_LIMIT = PROD_W'(102943);
    localparam logic [GAIN_W-1:0] ONE_Q16       = GAIN_W'(65536);
    localparam logic [Q30_W-1:0]  ONE_Q30       = Q30_W'(1073741824);
    localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    localparam logic [ANG_W-1:0] ANGLE_STEP_RST  = ANG_W'(99);
    localparam logic [ANG_W-1:0] RAMP_END_RST    = ANG_W'(1144);
    localparam logic [ANG_W-1:0] COSEC_START_RST = ANG_W'(2288);
    localparam logic [ANG_W-1:0] COVER_TOP_RST   = ANG_W'(45752);

    localparam logic signed [CW-1:0] ATAN_Q30 [CORDIC_STEPS] = '{
        34'sh03243F6A8, 34'sh01DAC6705, 34'sh00FADBAFC, 34'sh007F56EA6,
        34'sh003FEAB76, 34'sh001FFD55B, 34'sh000FFFAAA, 34'sh0007FFF55,
        34'sh0003FFFEA, 34'sh0001FFFFD, 34'sh0000FFFFF, 34'sh00007FFFF,
        34'sh00003FFFF, 34'sh00001FFFF, 34'sh00000FFFF, 34'sh000007FFF,
        34'sh000003FFF, 34'sh000001FFF, 34'sh000000FFF, 34'sh0000007FF,
        34'sh0000003FF, 34'sh0000001FF, 34'sh0000000FF, 34'sh00000007F
    };

    typedef enum logic [1:0] {
        REG_ANGLE_STEP  = 2'd0,
        REG_RAMP_END    = 2'd1,
        REG_COSEC_START = 2'd2,
        REG_COVER_TOP   = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_RAMP,
        KIND_FLAT,
        KIND_COSEC
    } gain_kind_t;

    typedef struct packed {
        logic             valid;
        gain_kind_t       kind;
        logic [ANG_W-1:0] ang;
    } angle_sb_t;

    typedef struct packed {
        logic             valid;
        gain_kind_t       kind;
        logic [Q30_W-1:0] s;
        logic [Q30_W-1:0] c;
    } trig_sb_t;

endpackage

### sv/ecpg_cordic.sv
module ecpg_cordic (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [ecpg_pkg::ANG_W-1:0]  angle,
    output logic [ecpg_pkg::Q30_W-1:0]  sin_q,
    output logic [ecpg_pkg::Q30_W-1:0]  cos_q
);
    import ecpg_pkg::*;

    logic signed [CW-1:0] x_reg [CORDIC_STEPS];
    logic signed [CW-1:0] y_reg [CORDIC_STEPS];
    logic signed [CW-1:0] z_reg [CORDIC_STEPS];
    logic [Q30_W-1:0]     sin_reg;
    logic [Q30_W-1:0]     cos_reg;
    logic signed [CW-1:0] x_last;
    logic signed [CW-1:0] y_last;

    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++) begin : g_step
            logic signed [CW-1:0] xi, yi, zi;
            if (i == 0) begin : g_first
                assign xi = CORDIC_GAIN_Q30;
                assign yi = '0;
                assign zi = signed'({3'b000, angle, 14'd0});
            end else begin : g_next
                assign xi = x_reg[i-1];
                assign yi = y_reg[i-1];
                assign zi = z_reg[i-1];
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    if (zi >= 0) begin
                        x_reg[i] <= xi - (yi >>> i);
                        y_reg[i] <= yi + (xi >>> i);
                        z_reg[i] <= zi - ATAN_Q30[i];
                    end else begin
                        x_reg[i] <= xi + (yi >>> i);
                        y_reg[i] <= yi - (xi >>> i);
                        z_reg[i] <= zi + ATAN_Q30[i];
                    end
                end
            end
        end
    endgenerate

    assign x_last = x_reg[CORDIC_STEPS-1];
    assign y_last = y_reg[CORDIC_STEPS-1];

    // clamp to [0, 1.0] in Q1.30
    always_ff @(posedge aclk) begin
        if (en) begin
            if (y_last < 0)
                sin_reg <= '0;
            else if (y_last > signed'(CW'(ONE_Q30)))
                sin_reg <= ONE_Q30;
            else
                sin_reg <= y_last[Q30_W-1:0];
            if (x_last < 0)
                cos_reg <= '0;
            else if (x_last > signed'(CW'(ONE_Q30)))
                cos_reg <= ONE_Q30;
            else
                cos_reg <= x_last[Q30_W-1:0];
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

### sv/ecpg_div.sv
module ecpg_div (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [ecpg_pkg::Q30_W-1:0]  num,
    input  logic [ecpg_pkg::Q30_W-1:0]  den,
    output logic [ecpg_pkg::GAIN_W-1:0] quot
);
    import ecpg_pkg::*;

    logic [Q30_W:0]       rem_reg [DIV_LAT];
    logic [Q30_W-1:0]     den_reg [DIV_LAT];
    logic [DIV_STEPS-1:0] q_reg   [DIV_LAT];
    logic                 sat_reg [DIV_LAT];

    // a numerator at or above the divisor saturates to one
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= {1'b0, num};
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            sat_reg[0] <= (num >= den);
        end
    end

    genvar k;
    generate
        for (k = 1; k < DIV_LAT; k++) begin : g_step
            logic [Q30_W:0] rem2;
            assign rem2 = {rem_reg[k-1][Q30_W-1:0], 1'b0};
            always_ff @(posedge aclk) begin
                if (en) begin
                    den_reg[k] <= den_reg[k-1];
                    sat_reg[k] <= sat_reg[k-1];
                    if (rem2 >= {1'b0, den_reg[k-1]}) begin
                        rem_reg[k] <= rem2 - {1'b0, den_reg[k-1]};
                        q_reg[k]   <= {q_reg[k-1][DIV_STEPS-2:0], 1'b1};
                    end else begin
                        rem_reg[k] <= rem2;
                        q_reg[k]   <= {q_reg[k-1][DIV_STEPS-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign quot = sat_reg[DIV_LAT-1] ? ONE_Q16 : {1'b0, q_reg[DIV_LAT-1]};

endmodule

### sv/elevation_coverage_point_generator_top.sv
// Elevation coverage point generator: for each point index the block forms
// the elevation e = (index+1) * angle_step (Q1.16 rad) and returns the
// cosecant-squared pattern gain with its ground and height projections.
// It takes one point per clock while the result side is not stalled. A
// result passes through the elevation register, the region pick register,
// the 24-step CORDIC and its clamp register, the restoring divider (an
// operand register and 16 steps), and the gain and projection registers;
// the first register is loaded at the edge that accepts its point. A stall
// on the result side holds the whole pipeline.
// Registers sit at byte addresses 0 (angle_step), 4 (ramp_end_angle),
// 8 (cosecant_start_angle) and 12 (coverage_top_angle). Write them only
// while the block is idle.
module elevation_coverage_point_generator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] point_index
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [16:0] pattern_gain, [33:17] ground_reach,
                                   // [50:34] height_reach
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ecpg_pkg::*;

    logic [ANG_W-1:0] angle_step_reg, ramp_end_reg, cosec_start_reg, cover_top_reg;
    reg_idx_t         reg_sel;
    logic             en;

    logic              v1_reg;
    logic [PROD_W-1:0] e1_reg;
    angle_sb_t         st2_reg;
    angle_sb_t         sb1_reg [CORDIC_LAT];
    trig_sb_t          sb2_reg [DIV_LAT];
    gain_kind_t        kind2_next;

    logic [Q30_W-1:0]  s_e, c_e, s_0, c_0;
    logic [Q30_W-1:0]  div_num, div_den;
    logic [GAIN_W-1:0] quot;

    logic              v3_reg;
    logic [GAIN_W-1:0] gain3_reg;
    logic [Q30_W-1:0]  s3_reg, c3_reg;
    logic              v4_reg;
    logic [GAIN_W-1:0] gain4_reg;
    logic [47:0]       prodc_reg, prods_reg;

    // configuration port
    assign reg_sel = reg_idx_t'(paddr[3:2]);
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_step_reg  <= ANGLE_STEP_RST;
            ramp_end_reg    <= RAMP_END_RST;
            cosec_start_reg <= COSEC_START_RST;
            cover_top_reg   <= COVER_TOP_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_sel)
                REG_ANGLE_STEP:  angle_step_reg  <= pwdata[ANG_W-1:0];
                REG_RAMP_END:    ramp_end_reg    <= pwdata[ANG_W-1:0];
                REG_COSEC_START: cosec_start_reg <= pwdata[ANG_W-1:0];
                REG_COVER_TOP:   cover_top_reg   <= pwdata[ANG_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_ANGLE_STEP:  prdata = {15'd0, angle_step_reg};
            REG_RAMP_END:    prdata = {15'd0, ramp_end_reg};
            REG_COSEC_START: prdata = {15'd0, cosec_start_reg};
            REG_COVER_TOP:   prdata = {15'd0, cover_top_reg};
            default:         prdata = '0;
        endcase
    end

    // hold every stage while the output transaction is stalled
    assign en       = !v4_reg || m_tready;
    assign s_tready = en;

    // stage 1: elevation
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e1_reg <= (PROD_W'(s_tdata[IDX_W-1:0]) + PROD_W'(1)) * PROD_W'(angle_step_reg);
        end
    end

    // stage 2: pick the pattern region
    always_comb begin
        priority if (e1_reg > HALF_PI_LIMIT || e1_reg == '0)
            kind2_next = KIND_ZERO;
        else if (e1_reg <= PROD_W'(ramp_end_reg))
            kind2_next = KIND_RAMP;
        else if (e1_reg < PROD_W'(cosec_start_reg))
            kind2_next = KIND_FLAT;
        else if (e1_reg <= PROD_W'(cover_top_reg))
            kind2_next = KIND_COSEC;
        else
            kind2_next = KIND_ZERO;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st2_reg.valid <= 1'b0;
        end else if (en) begin
            st2_reg.valid <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st2_reg.kind <= kind2_next;
            st2_reg.ang  <= e1_reg[ANG_W-1:0];
        end
    end

    // sine and cosine of the elevation and of the falloff start
    ecpg_cordic u_cordic_e (
        .aclk  (aclk),
        .en    (en),
        .angle (st2_reg.ang),
        .sin_q (s_e),
        .cos_q (c_e)
    );

    ecpg_cordic u_cordic_0 (
        .aclk  (aclk),
        .en    (en),
        .angle (cosec_start_reg),
        .sin_q (s_0),
        .cos_q (c_0)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < CORDIC_LAT; k++) sb1_reg[k].valid <= 1'b0;
        end else if (en) begin
            sb1_reg[0] <= st2_reg;
            for (int k = 1; k < CORDIC_LAT; k++) sb1_reg[k] <= sb1_reg[k-1];
        end
    end

    // divider operands: ramp is e / ramp_end, falloff is sin(start) / sin(e)
    always_comb begin
        if (sb1_reg[CORDIC_LAT-1].kind == KIND_RAMP) begin
            div_num = {14'd0, sb1_reg[CORDIC_LAT-1].ang};
            div_den = {14'd0, ramp_end_reg};
        end else begin
            div_num = s_0;
            div_den = s_e;
        end
    end

    ecpg_div u_div (
        .aclk (aclk),
        .en   (en),
        .num  (div_num),
        .den  (div_den),
        .quot (quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DIV_LAT; k++) sb2_reg[k].valid <= 1'b0;
        end else if (en) begin
            sb2_reg[0].valid <= sb1_reg[CORDIC_LAT-1].valid;
            sb2_reg[0].kind  <= sb1_reg[CORDIC_LAT-1].kind;
            sb2_reg[0].s     <= s_e;
            sb2_reg[0].c     <= c_e;
            for (int k = 1; k < DIV_LAT; k++) sb2_reg[k] <= sb2_reg[k-1];
        end
    end

    // gain stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= sb2_reg[DIV_LAT-1].valid;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            unique case (sb2_reg[DIV_LAT-1].kind)
                KIND_ZERO:  gain3_reg <= '0;
                KIND_FLAT:  gain3_reg <= ONE_Q16;
                KIND_RAMP:  gain3_reg <= quot;
                KIND_COSEC: gain3_reg <= quot;
                default:    gain3_reg <= '0;
            endcase
            s3_reg <= sb2_reg[DIV_LAT-1].s;
            c3_reg <= sb2_reg[DIV_LAT-1].c;
        end
    end

    // projection stage, also the output register
    always_ff @(posedge aclk) begin
        if (en) begin
            gain4_reg <= gain3_reg;
            prodc_reg <= gain3_reg * c3_reg;
            prods_reg <= gain3_reg * s3_reg;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {5'd0, prods_reg[46:30], prodc_reg[46:30], gain4_reg};

endmodule

### sv/ecpg_checker.sv
`include "assert_macros.svh"

module ecpg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    `ECPG_ASSERT(a_valid_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "output valid dropped while stalled")
    `ECPG_ASSERT_HOLD(a_data_hold, aclk, aresetn, m_tvalid && !m_tready, m_tdata, "output data changed while stalled")
    `ECPG_ASSERT(a_gain_max, aclk, aresetn, m_tvalid |-> m_tdata[16:0] <= 17'd65536, "gain above one")
    `ECPG_ASSERT(a_reach_le_gain, aclk, aresetn, m_tvalid |-> (m_tdata[33:17] <= m_tdata[16:0]) && (m_tdata[50:34] <= m_tdata[16:0]), "projection exceeds gain")
    `ECPG_ASSERT(a_accept_when_empty, aclk, aresetn, !m_tvalid || m_tready |-> s_tready, "input blocked with free output")

endmodule

bind elevation_coverage_point_generator_top ecpg_checker u_ecpg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
